// ===== rtl/mmba_pkg.sv =====
// Shared types and constants of the memory-map bump allocator.
// Holds the microcode table of the sequencer, the item and status codes
// and the register indexes. Depends on nothing else.
`default_nettype none

package mmba_pkg;

   // Packed widths of the stream payloads.
   localparam int REQ_TDATA_W = 168;
   localparam int RSP_TDATA_W = 72;

   localparam int CSR_INDEX_W = 2;
   localparam int COUNT_W     = 5;
   localparam int NEED_W      = 33;
   localparam int STEP_W      = 5;

   // Allocation sizes and raised region bases are rounded up to 16 byte boundaries.
   localparam logic [63:0] ALIGN_MASK  = 64'hF;
   localparam logic [63:0] RESET_BORDER = 64'd1048576;

   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_BASE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_BORDER = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENTRY_COUNT  = 2'd2;

   typedef enum logic [1:0] {
      OP_WRITE_ENTRY = 2'd0,
      OP_OPEN        = 2'd1,
      OP_ALLOCATE    = 2'd2,
      OP_TERMINATE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_CLOSED    = 2'd1,
      STATUS_NO_MEMORY = 2'd2
   } status_type;

   // Addresses of the microcode program.
   typedef enum logic [STEP_W-1:0] {
      ST_IDLE      = 5'd0,
      ST_DEC_WRITE = 5'd1,
      ST_DEC_OPEN  = 5'd2,
      ST_DEC_TERM  = 5'd3,
      ST_CHK_OPEN  = 5'd4,
      ST_SCAN      = 5'd5,
      ST_LOAD      = 5'd6,
      ST_TEST      = 5'd7,
      ST_DIFF      = 5'd8,
      ST_FIT       = 5'd9,
      ST_NEXT      = 5'd10,
      ST_TAKE      = 5'd11,
      ST_NO_MEM    = 5'd12,
      ST_CLOSED    = 5'd13,
      ST_WRITE     = 5'd14,
      ST_OPEN      = 5'd15,
      ST_TERM      = 5'd16,
      ST_EMIT      = 5'd17,
      ST_RETURN    = 5'd18
   } step_type;

   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_REQ,
      C_OP_WRITE,
      C_OP_OPEN,
      C_OP_TERM,
      C_CLOSED,
      C_SCAN_DONE,
      C_SKIP,
      C_FIT,
      C_OUT_BUSY
   } cond_type;

   typedef enum logic [3:0] {
      A_NONE,
      A_LATCH,
      A_LOAD,
      A_RAISE,
      A_DIFF,
      A_NEXT,
      A_TAKE,
      A_NO_MEM,
      A_CLOSED,
      A_WRITE,
      A_OPEN,
      A_TERM,
      A_EMIT
   } action_type;

   typedef struct packed {
      cond_type   cond;
      step_type   target;
      action_type action;
      logic       take_req;
   } ctrl_word_type;

   function automatic ctrl_word_type ucode_word(input cond_type c, input step_type t,
                                                input action_type a, input logic r);
      ctrl_word_type w;
      w.cond     = c;
      w.target   = t;
      w.action   = a;
      w.take_req = r;
      return w;
   endfunction

   // The program: when the condition holds the step jumps to its target,
   // otherwise it falls through to the next address.
   function automatic ctrl_word_type ucode_rom(input step_type step);
      ctrl_word_type w;
      case (step)
         ST_IDLE:      w = ucode_word(C_NO_REQ,    ST_IDLE,   A_LATCH,  1'b1);
         ST_DEC_WRITE: w = ucode_word(C_OP_WRITE,  ST_WRITE,  A_NONE,   1'b0);
         ST_DEC_OPEN:  w = ucode_word(C_OP_OPEN,   ST_OPEN,   A_NONE,   1'b0);
         ST_DEC_TERM:  w = ucode_word(C_OP_TERM,   ST_TERM,   A_NONE,   1'b0);
         ST_CHK_OPEN:  w = ucode_word(C_CLOSED,    ST_CLOSED, A_NONE,   1'b0);
         ST_SCAN:      w = ucode_word(C_SCAN_DONE, ST_NO_MEM, A_NONE,   1'b0);
         ST_LOAD:      w = ucode_word(C_NEVER,     ST_IDLE,   A_LOAD,   1'b0);
         ST_TEST:      w = ucode_word(C_SKIP,      ST_NEXT,   A_RAISE,  1'b0);
         ST_DIFF:      w = ucode_word(C_NEVER,     ST_IDLE,   A_DIFF,   1'b0);
         ST_FIT:       w = ucode_word(C_FIT,       ST_TAKE,   A_NONE,   1'b0);
         ST_NEXT:      w = ucode_word(C_ALWAYS,    ST_SCAN,   A_NEXT,   1'b0);
         ST_TAKE:      w = ucode_word(C_ALWAYS,    ST_EMIT,   A_TAKE,   1'b0);
         ST_NO_MEM:    w = ucode_word(C_ALWAYS,    ST_EMIT,   A_NO_MEM, 1'b0);
         ST_CLOSED:    w = ucode_word(C_ALWAYS,    ST_EMIT,   A_CLOSED, 1'b0);
         ST_WRITE:     w = ucode_word(C_ALWAYS,    ST_EMIT,   A_WRITE,  1'b0);
         ST_OPEN:      w = ucode_word(C_ALWAYS,    ST_EMIT,   A_OPEN,   1'b0);
         ST_TERM:      w = ucode_word(C_ALWAYS,    ST_EMIT,   A_TERM,   1'b0);
         ST_EMIT:      w = ucode_word(C_OUT_BUSY,  ST_EMIT,   A_EMIT,   1'b0);
         ST_RETURN:    w = ucode_word(C_ALWAYS,    ST_IDLE,   A_NONE,   1'b0);
         default:      w = ucode_word(C_ALWAYS,    ST_IDLE,   A_NONE,   1'b0);
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/memory_map_bump_allocator_unit.sv =====
// Top level of the memory-map bump allocator: microcoded sequencer,
// region table memory and the 64-bit datapath. Depends on mmba_pkg.
`default_nettype none

// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  req_tdata: one operation item
// rsp      out        rsp_tvalid/rsp_tready  rsp_tdata: address and status
// csr      in         csr_valid/csr_ready    csr_index, csr_wdata
//
// An item is decoded and worked on, and its result emitted, before the sequencer
// passes its return step back to idle, where the next item can be accepted. An
// open allocation scans the table entries in order: each entry is loaded from the
// registered table read, tested and either skipped or, after its remaining room is
// formed, checked for fit. A closed allocator or a scan that runs out of entries
// gives a status and a zero address.
// Reset is synchronous; no clearing pass is needed. A stalled result holds
// the sequencer at its emit step; a result already waiting does not stop the
// next item being accepted and worked on.

module memory_map_bump_allocator_unit #(
   parameter int MAX_REGIONS = 16,
   parameter int PAGE_SHIFT  = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // operation[1:0], entry_index[5:2], entry_start[69:6], entry_size[133:70],
   // entry_is_usable[134], alloc_size[166:135], zero[167]
   input  logic [mmba_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // address[63:0], status[65:64], zero[71:66]
   output logic [mmba_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mmba_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [63:0]                         csr_wdata
);
   import mmba_pkg::*;

   localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int CNT_W = $clog2(MAX_REGIONS + 1);
   localparam int LIM_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
   localparam logic [LIM_W-1:0] MAX_LIM   = LIM_W'(MAX_REGIONS);
   localparam logic [63:0]      PAGE_MASK = (64'd1 << PAGE_SHIFT) - 64'd1;

   // Sequencer.
   step_type      step_ff, step_in;
   ctrl_word_type ctrl;
   logic          cond_hit;
   logic          req_accept;
   logic          csr_write;
   logic          out_busy;

   // Control state.
   logic [63:0]        window_base_ff;
   logic [COUNT_W-1:0] entry_count_ff;
   logic [63:0]        border_ff;
   logic [CNT_W-1:0]   scan_ff;
   logic               is_open_ff;
   logic               usable_ff [MAX_REGIONS];
   logic               rsp_tvalid_ff;

   // Latched item.
   op_type            item_op_ff;
   logic [3:0]        item_index_ff;
   logic [63:0]       item_start_ff;
   logic [63:0]       item_size_ff;
   logic              item_usable_ff;
   logic [NEED_W-1:0] need_ff;
   logic [NEED_W-1:0] need_in;

   // Region table.
   logic [63:0]       base_mem [MAX_REGIONS];
   logic [63:0]       len_mem  [MAX_REGIONS];
   logic [IDX_W-1:0]  wr_idx;
   logic [IDX_W-1:0]  rd_idx;
   logic              wr_en;
   logic [63:0]       rd_base_ff;
   logic [63:0]       rd_len_ff;
   logic              rd_usable_ff;

   // Datapath.
   logic [63:0]       end_ff;
   logic [63:0]       rnd_ff;
   logic              rnd_ovf_ff;
   logic [64:0]       rnd_sum;
   logic [63:0]       remain_ff;
   logic              le_ff;
   logic [63:0]       res_addr_ff;
   status_type        res_status_ff;
   logic [63:0]       rsp_addr_ff;
   status_type        rsp_status_ff;
   logic [LIM_W-1:0]  count_ext;
   logic [LIM_W-1:0]  limit;
   logic              scan_done;
   logic              border_lt_end;
   logic              border_lt_base;
   logic              skip;
   logic              fit;

   assign req_accept = req_tvalid && req_tready;
   assign csr_write  = csr_valid && csr_ready;
   assign req_tready = ctrl.take_req;
   assign csr_ready  = 1'b1;
   assign out_busy   = rsp_tvalid_ff && !rsp_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {6'b0, rsp_status_ff, rsp_addr_ff};

   assign need_in = ({1'b0, req_tdata[166:135]} + NEED_W'(ALIGN_MASK)) & ~NEED_W'(ALIGN_MASK);

   assign wr_idx = IDX_W'(item_index_ff);
   assign rd_idx = scan_ff[IDX_W-1:0];
   assign wr_en  = (ctrl.action == A_WRITE) && (int'(item_index_ff) < MAX_REGIONS);

   // An entry count above the table size scans the whole table only.
   assign count_ext = LIM_W'(entry_count_ff);
   assign limit     = (count_ext > MAX_LIM) ? MAX_LIM : count_ext;
   assign scan_done = LIM_W'(scan_ff) >= limit;

   assign border_lt_end  = border_ff < end_ff;
   assign border_lt_base = border_ff < rd_base_ff;
   assign skip = !rd_usable_ff || !border_lt_end || (border_lt_base && rnd_ovf_ff);
   assign fit  = le_ff && (remain_ff >= 64'(need_ff));

   assign rnd_sum = {1'b0, rd_base_ff} + {1'b0, ALIGN_MASK};

   always_comb begin
      ctrl = ucode_rom(step_ff);
   end

   always_comb begin
      case (ctrl.cond)
         C_NEVER:     cond_hit = 1'b0;
         C_ALWAYS:    cond_hit = 1'b1;
         C_NO_REQ:    cond_hit = !req_accept;
         C_OP_WRITE:  cond_hit = item_op_ff == OP_WRITE_ENTRY;
         C_OP_OPEN:   cond_hit = item_op_ff == OP_OPEN;
         C_OP_TERM:   cond_hit = item_op_ff == OP_TERMINATE;
         C_CLOSED:    cond_hit = !is_open_ff;
         C_SCAN_DONE: cond_hit = scan_done;
         C_SKIP:      cond_hit = skip;
         C_FIT:       cond_hit = fit;
         C_OUT_BUSY:  cond_hit = out_busy;
         default:     cond_hit = 1'b0;
      endcase
   end

   always_comb begin
      if (cond_hit) begin
         step_in = ctrl.target;
      end else begin
         step_in = step_type'(STEP_W'(step_ff) + STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff        <= ST_IDLE;
         window_base_ff <= '0;
         entry_count_ff <= '0;
         border_ff      <= RESET_BORDER;
         scan_ff        <= '0;
         is_open_ff     <= 1'b0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         step_ff <= step_in;

         if (csr_write) begin
            case (csr_index)
               CSR_WINDOW_BASE:  window_base_ff <= csr_wdata;
               CSR_START_BORDER: border_ff      <= csr_wdata;
               CSR_ENTRY_COUNT:  entry_count_ff <= csr_wdata[COUNT_W-1:0];
               default: ;
            endcase
         end

         // A border raised to a region base stays raised even if the entry
         // then turns out to be too small.
         if (ctrl.action == A_RAISE && !skip && border_lt_base) begin
            border_ff <= rnd_ff;
         end
         if (ctrl.action == A_TAKE) begin
            border_ff <= border_ff + 64'(need_ff);
         end

         if (ctrl.action == A_NEXT) begin
            scan_ff <= scan_ff + CNT_W'(1);
         end

         if (ctrl.action == A_OPEN) begin
            is_open_ff <= 1'b1;
         end else if (ctrl.action == A_TERM) begin
            is_open_ff <= 1'b0;
         end

         if (ctrl.action == A_EMIT && !out_busy) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         usable_ff <= '{default: 1'b0};
      end else if (wr_en) begin
         usable_ff[wr_idx] <= item_usable_ff;
      end
   end

   // Region table: one write port, one registered read port at the scan index.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         base_mem[wr_idx] <= item_start_ff;
         len_mem[wr_idx]  <= item_size_ff;
      end
      rd_base_ff   <= base_mem[rd_idx];
      rd_len_ff    <= len_mem[rd_idx];
      rd_usable_ff <= usable_ff[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (ctrl.action == A_LATCH && req_accept) begin
         item_op_ff     <= op_type'(req_tdata[1:0]);
         item_index_ff  <= req_tdata[5:2];
         item_start_ff  <= req_tdata[69:6];
         item_size_ff   <= req_tdata[133:70];
         item_usable_ff <= req_tdata[134];
         need_ff        <= need_in;
      end

      case (ctrl.action)
         A_LOAD: begin
            end_ff     <= rd_base_ff + rd_len_ff;
            rnd_ff     <= rnd_sum[63:0] & ~ALIGN_MASK;
            rnd_ovf_ff <= rnd_sum[64];
         end
         A_DIFF: begin
            remain_ff <= end_ff - border_ff;
            le_ff     <= border_ff <= end_ff;
         end
         A_TAKE: begin
            res_addr_ff   <= window_base_ff + border_ff;
            res_status_ff <= STATUS_OK;
         end
         A_NO_MEM: begin
            res_addr_ff   <= '0;
            res_status_ff <= STATUS_NO_MEMORY;
         end
         A_CLOSED: begin
            res_addr_ff   <= '0;
            res_status_ff <= STATUS_CLOSED;
         end
         A_WRITE, A_OPEN: begin
            res_addr_ff   <= '0;
            res_status_ff <= STATUS_OK;
         end
         A_TERM: begin
            res_addr_ff   <= (border_ff + PAGE_MASK) & ~PAGE_MASK;
            res_status_ff <= STATUS_OK;
         end
         A_EMIT: begin
            if (!out_busy) begin
               rsp_addr_ff   <= res_addr_ff;
               rsp_status_ff <= res_status_ff;
            end
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire
